### rtl/psx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psx_pkg
// Shared widths, codes and types of the polyline section extractor.
// ----------------------------------------------------------------------------
package psx_pkg;

  localparam int COORD_FRAC_BITS_DEF = 30;
  localparam int COORD_W    = 40;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int LEN_W      = 48;
  localparam int MM_W       = 32;
  localparam int MM_PER_DEG = 111320 * 1000;
  localparam int MM_REM_W   = 27;
  localparam int SEG_W      = 43;
  localparam int SQ_W       = 2 * SEG_W;
  localparam int REM_W      = SEG_W + 3;
  localparam int FACT_BITS  = 32;
  localparam int FACT_W     = FACT_BITS + 1;
  localparam int PROD_W     = DIFF_W + FACT_W;
  localparam int STEP_W     = 6;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END   = 1'b1;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_MID    = 2'd1,
    KIND_END    = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD       = 2'd1,
    ST_UNREACHED = 2'd2
  } status_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQ     = 8'b0000_0010,
    S_ROOT   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_NEXT   = 8'b0001_0000,
    S_FACT   = 8'b0010_0000,
    S_MUL    = 8'b0100_0000,
    S_PUT    = 8'b1000_0000
  } state_t;

  function automatic status_t status_of(input logic bad, input logic [1:0] cnt,
                                        input logic end_em);
    status_t s;
    if (bad || cnt < 2'd2) s = ST_BAD;
    else if (!end_em)      s = ST_UNREACHED;
    else                   s = ST_OK;
    return s;
  endfunction

endpackage

### rtl/psx_mm2deg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psx_mm2deg
// Bit-serial division of a chainage in millimetres by millimetres per degree,
// giving degrees with COORD_FRAC_BITS fraction bits, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module psx_mm2deg #(
  parameter int COORD_FRAC_BITS = psx_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [psx_pkg::MM_W-1:0]    mm,
  output logic [psx_pkg::LEN_W-1:0]   deg
);

  localparam int STEPS = psx_pkg::MM_W + COORD_FRAC_BITS;
  localparam int CW    = $clog2(STEPS + 1);

  logic [psx_pkg::MM_W-1:0]     sh_r;
  logic [psx_pkg::MM_REM_W-1:0] rem_r;
  logic [psx_pkg::LEN_W-1:0]    q_r;
  logic [CW-1:0]                cnt_r;
  logic [psx_pkg::MM_REM_W:0]   trial;
  logic                         ge;
  logic [psx_pkg::MM_REM_W:0]   rem_nxt;

  always_comb begin
    trial   = {rem_r, sh_r[psx_pkg::MM_W-1]};
    ge      = trial >= (psx_pkg::MM_REM_W+1)'(psx_pkg::MM_PER_DEG);
    rem_nxt = ge ? trial - (psx_pkg::MM_REM_W+1)'(psx_pkg::MM_PER_DEG) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= mm;
      rem_r <= '0;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      sh_r  <= {sh_r[psx_pkg::MM_W-2:0], 1'b0};
      rem_r <= rem_nxt[psx_pkg::MM_REM_W-1:0];
      q_r   <= {q_r[psx_pkg::LEN_W-2:0], ge};
    end
  end

  assign deg = q_r;

endmodule

### rtl/polyline_section_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_section_extractor
// Cuts the section between two chainages out of a stream of polyline
// vertices: start cut, interior vertices, end cut, and a status per line.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  in_      in   tdata = vertex_x, vertex_y; tlast = final_vertex
//  out_     out  tdata = point_x, point_y; tuser = point_kind, status;
//                tlast = run_last
//  cfg_     in   cfg_addr 0 start_position_mm, 1 end_position_mm
//
//  a segment vertex passes the squaring, square root and control states and
//  then puts its result beats, and each cut adds a divide and a multiply
//  (no divide when the factor is 0 or one); the first vertex and vertices
//  after the end cut skip the squaring, root and cut arithmetic
//  one vertex is in flight at a time; output stalls hold the sequencer
//  synchronous active-low reset clears line state and registers, no sweep
// ----------------------------------------------------------------------------
module polyline_section_extractor #(
  parameter int COORD_FRAC_BITS = psx_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [2*psx_pkg::COORD_W-1:0]       in_tdata,   // vertex_x, vertex_y
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [2*psx_pkg::COORD_W-1:0]       out_tdata,  // point_x, point_y
  output logic [3:0]                          out_tuser,  // point_kind, status
  output logic                                out_tlast,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_addr,
  input  logic [psx_pkg::MM_W-1:0]            cfg_data
);

  localparam int CW = psx_pkg::COORD_W;
  localparam int DW = psx_pkg::DIFF_W;
  localparam int LW = psx_pkg::LEN_W;
  localparam int SW = psx_pkg::SEG_W;
  localparam int FW = psx_pkg::FACT_W;
  localparam int PW = psx_pkg::PROD_W;
  localparam int QW = psx_pkg::SQ_W;
  localparam int RW = psx_pkg::REM_W;
  localparam int TW = psx_pkg::STEP_W;

  psx_pkg::state_t  state_r;
  psx_pkg::kind_t   kind_r;
  psx_pkg::status_t st_r;

  logic [psx_pkg::MM_W-1:0] cfg_start_r, cfg_end_r;
  logic [CW-1:0] cx_r, cy_r, prev_x_r, prev_y_r;
  logic          fin_r, bad_r, upd_prev_r;
  logic [LW-1:0] len_r, total_r;
  logic          have_r, sem_r, eem_r;
  logic [1:0]    cnt_pts_r;
  logic [DW-1:0] adx_r, ady_r, mx_r, my_r;
  logic          sgnx_r, sgny_r;
  logic [QW-1:0] nr_r;
  logic [SW-1:0] root_r;
  logic [RW-1:0] rem_r;
  logic [TW-1:0] step_r;
  logic [3:0]    need_r;
  logic [FW-1:0] f_r;
  logic [SW:0]   div_r;
  logic [PW-1:0] accx_r, accy_r;

  logic [CW-1:0] out_x_r, out_y_r;
  logic [1:0]    out_kind_r, out_st_r;
  logic          out_last_r, out_valid_r;

  logic [LW-1:0] s_deg, e_deg;
  logic          conv_start;

  logic          in_acc, out_free;
  logic [CW-1:0] in_x, in_y;
  logic [DW-1:0] dx, dy, adx, ady;

  logic [RW-1:0] rem_sh, root_trial;
  logic          root_ge;
  logic [LW:0]   tot_sum;
  logic [LW-1:0] total;
  logic          ns, nm, ne, se;
  logic [2:0]    pts_sum;
  logic [1:0]    cnt_nxt;
  logic [LW-1:0] chain, n_cut;
  logic [SW:0]   div_sh;
  logic          div_ge;
  logic [DW:0]   offx, offy;
  logic [CW-1:0] cut_x, cut_y;
  logic [3:0]    need_left;

  assign in_x = in_tdata[CW-1:0];
  assign in_y = in_tdata[2*CW-1:CW];
  assign in_tready = (state_r == psx_pkg::S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign conv_start = in_acc && have_r && !eem_r;

  psx_mm2deg #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_conv_s (
    .clk(clk), .rst_n(rst_n), .start(conv_start), .mm(cfg_start_r), .deg(s_deg)
  );
  psx_mm2deg #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_conv_e (
    .clk(clk), .rst_n(rst_n), .start(conv_start), .mm(cfg_end_r), .deg(e_deg)
  );

  always_comb begin
    dx  = {in_x[CW-1], in_x} - {prev_x_r[CW-1], prev_x_r};
    dy  = {in_y[CW-1], in_y} - {prev_y_r[CW-1], prev_y_r};
    adx = dx[DW-1] ? -dx : dx;
    ady = dy[DW-1] ? -dy : dy;

    rem_sh     = {rem_r[RW-3:0], nr_r[QW-1:QW-2]};
    root_trial = {1'b0, root_r, 2'b01};
    root_ge    = rem_sh >= root_trial;

    tot_sum = {1'b0, len_r} + {{(LW-SW+1){1'b0}}, root_r};
    total   = tot_sum[LW] ? '1 : tot_sum[LW-1:0];
    ns      = !bad_r && !sem_r && (total >= s_deg);
    se      = sem_r || ns;
    nm      = !bad_r && se && (total <= e_deg);
    ne      = !bad_r && (total >= e_deg);
    pts_sum = {1'b0, cnt_pts_r} + {2'b0, ns} + {2'b0, nm} + {2'b0, ne};
    cnt_nxt = (pts_sum >= 3'd2) ? 2'd2 : pts_sum[1:0];

    chain  = need_r[0] ? s_deg : e_deg;
    n_cut  = (chain > len_r) ? chain - len_r : '0;

    div_sh = {div_r[SW-1:0], 1'b0};
    div_ge = div_sh >= {1'b0, root_r};

    offx  = accx_r[PW-1:psx_pkg::FACT_BITS];
    offy  = accy_r[PW-1:psx_pkg::FACT_BITS];
    cut_x = sgnx_r ? prev_x_r - offx[CW-1:0] : prev_x_r + offx[CW-1:0];
    cut_y = sgny_r ? prev_y_r - offy[CW-1:0] : prev_y_r + offy[CW-1:0];

    need_left = need_r & ~(4'b0001 << kind_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_start_r <= '0;
      cfg_end_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        psx_pkg::CFG_START: cfg_start_r <= cfg_data;
        psx_pkg::CFG_END:   cfg_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psx_pkg::S_IDLE;
      need_r      <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      len_r       <= '0;
      have_r      <= 1'b0;
      sem_r       <= 1'b0;
      eem_r       <= 1'b0;
      cnt_pts_r   <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (out_valid_r && out_tready && state_r != psx_pkg::S_PUT) out_valid_r <= 1'b0;
      unique case (state_r)
        psx_pkg::S_IDLE: begin
          if (in_acc) begin
            cx_r    <= in_x;
            cy_r    <= in_y;
            fin_r   <= in_tlast;
            bad_r   <= cfg_start_r >= cfg_end_r;
            total_r <= len_r;
            if (!have_r) begin
              upd_prev_r <= 1'b1;
              need_r     <= {in_tlast, 3'b000};
              st_r       <= psx_pkg::ST_BAD;
              state_r    <= psx_pkg::S_NEXT;
            end else if (eem_r) begin
              upd_prev_r <= 1'b0;
              need_r     <= {in_tlast, 3'b000};
              st_r       <= psx_pkg::status_of(cfg_start_r >= cfg_end_r, cnt_pts_r, eem_r);
              state_r    <= psx_pkg::S_NEXT;
            end else begin
              upd_prev_r <= 1'b1;
              adx_r   <= adx;
              ady_r   <= ady;
              mx_r    <= adx;
              my_r    <= ady;
              sgnx_r  <= dx[DW-1];
              sgny_r  <= dy[DW-1];
              nr_r    <= '0;
              step_r  <= TW'(DW);
              state_r <= psx_pkg::S_SQ;
            end
          end
        end
        psx_pkg::S_SQ: begin
          nr_r <= {nr_r[QW-2:0], 1'b0}
                  + (mx_r[DW-1] ? {{(QW-DW){1'b0}}, adx_r} : '0)
                  + (my_r[DW-1] ? {{(QW-DW){1'b0}}, ady_r} : '0);
          mx_r   <= {mx_r[DW-2:0], 1'b0};
          my_r   <= {my_r[DW-2:0], 1'b0};
          if (step_r == TW'(1)) begin
            rem_r   <= '0;
            root_r  <= '0;
            step_r  <= TW'(SW);
            state_r <= psx_pkg::S_ROOT;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        psx_pkg::S_ROOT: begin
          rem_r  <= root_ge ? rem_sh - root_trial : rem_sh;
          root_r <= {root_r[SW-2:0], root_ge};
          nr_r   <= {nr_r[QW-3:0], 2'b00};
          step_r <= step_r - 1'b1;
          if (step_r == TW'(1)) state_r <= psx_pkg::S_DECIDE;
        end
        psx_pkg::S_DECIDE: begin
          need_r    <= {fin_r, ne, nm, ns};
          sem_r     <= se;
          eem_r     <= eem_r || ne;
          cnt_pts_r <= cnt_nxt;
          total_r   <= total;
          st_r      <= psx_pkg::status_of(bad_r, cnt_nxt, eem_r || ne);
          state_r   <= psx_pkg::S_NEXT;
        end
        psx_pkg::S_NEXT: begin
          accx_r <= '0;
          accy_r <= '0;
          priority if (need_r[0] || (!need_r[1] && need_r[2])) begin
            kind_r <= need_r[0] ? psx_pkg::KIND_START : psx_pkg::KIND_END;
            if (root_r == '0) begin
              f_r     <= '0;
              step_r  <= TW'(FW);
              state_r <= psx_pkg::S_MUL;
            end else if (n_cut >= {{(LW-SW){1'b0}}, root_r}) begin
              f_r     <= FW'(1) << psx_pkg::FACT_BITS;
              step_r  <= TW'(FW);
              state_r <= psx_pkg::S_MUL;
            end else begin
              f_r     <= '0;
              div_r   <= {1'b0, n_cut[SW-1:0]};
              step_r  <= TW'(psx_pkg::FACT_BITS);
              state_r <= psx_pkg::S_FACT;
            end
          end else if (need_r[1]) begin
            kind_r  <= psx_pkg::KIND_MID;
            state_r <= psx_pkg::S_PUT;
          end else if (need_r[3]) begin
            kind_r  <= psx_pkg::KIND_STATUS;
            state_r <= psx_pkg::S_PUT;
          end else begin
            if (fin_r) begin
              prev_x_r  <= '0;
              prev_y_r  <= '0;
              len_r     <= '0;
              have_r    <= 1'b0;
              sem_r     <= 1'b0;
              eem_r     <= 1'b0;
              cnt_pts_r <= '0;
            end else if (upd_prev_r) begin
              prev_x_r <= cx_r;
              prev_y_r <= cy_r;
              len_r    <= total_r;
              have_r   <= 1'b1;
            end
            state_r <= psx_pkg::S_IDLE;
          end
        end
        psx_pkg::S_FACT: begin
          div_r  <= div_ge ? div_sh - {1'b0, root_r} : div_sh;
          f_r    <= {f_r[FW-2:0], div_ge};
          if (step_r == TW'(1)) begin
            step_r  <= TW'(FW);
            state_r <= psx_pkg::S_MUL;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        psx_pkg::S_MUL: begin
          accx_r <= {accx_r[PW-2:0], 1'b0}
                    + (f_r[FW-1] ? {{(PW-DW){1'b0}}, adx_r} : '0);
          accy_r <= {accy_r[PW-2:0], 1'b0}
                    + (f_r[FW-1] ? {{(PW-DW){1'b0}}, ady_r} : '0);
          f_r    <= {f_r[FW-2:0], 1'b0};
          step_r <= step_r - 1'b1;
          if (step_r == TW'(1)) state_r <= psx_pkg::S_PUT;
        end
        psx_pkg::S_PUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= kind_r;
            out_last_r  <= (need_left == '0);
            need_r      <= need_left;
            state_r     <= psx_pkg::S_NEXT;
            unique case (kind_r)
              psx_pkg::KIND_START, psx_pkg::KIND_END: begin
                out_x_r  <= cut_x;
                out_y_r  <= cut_y;
                out_st_r <= psx_pkg::ST_OK;
              end
              psx_pkg::KIND_MID: begin
                out_x_r  <= cx_r;
                out_y_r  <= cy_r;
                out_st_r <= psx_pkg::ST_OK;
              end
              psx_pkg::KIND_STATUS: begin
                out_x_r  <= '0;
                out_y_r  <= '0;
                out_st_r <= st_r;
              end
              default: ;
            endcase
          end
        end
        default: state_r <= psx_pkg::S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = {out_st_r, out_kind_r};
  assign out_tlast  = out_last_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready) else $error("accepted a vertex without leaving idle");

  a_end_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    eem_r |-> sem_r) else $error("end cut without start cut");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == psx_pkg::KIND_STATUS) |-> out_last_r)
    else $error("status beat not marked last");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polyline section extractor. A directed table
// (extreme coordinates, bad range, single vertex, zero-length segment,
// end cut, unreached end, register change mid-line) is followed by random
// polylines: random walks cut at random chainages, plus full-range noise.
// Every output beat is checked against a bit-exact section predictor; in the
// later random phases the input and output sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int  FRAC       = psx_pkg::COORD_FRAC_BITS_DEF;
  localparam int  N_ITEMS    = 360;
  localparam int  SETTLE_CYC = 400;
  localparam logic [63:0] LEN_SAT = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [psx_pkg::COORD_W-1:0] x;
    logic signed [psx_pkg::COORD_W-1:0] y;
    psx_pkg::kind_t                     kind;
    psx_pkg::status_t                   st;
    logic                               last;
  } point_t;

  typedef enum logic {OP_VTX, OP_CFG} op_t;

  typedef struct {
    op_t                                op;
    logic signed [psx_pkg::COORD_W-1:0] x;
    logic signed [psx_pkg::COORD_W-1:0] y;
    logic                               last;
    logic                               addr;
    logic [psx_pkg::MM_W-1:0]           data;
    bit                                 typed;
    point_t                             exp;
  } row_t;

  logic                           clk, rst_n;
  logic                           in_tvalid, in_tready, in_tlast;
  logic [2*psx_pkg::COORD_W-1:0]  in_tdata;   // vertex_x, vertex_y
  logic                           out_tvalid, out_tready, out_tlast;
  logic [2*psx_pkg::COORD_W-1:0]  out_tdata;  // point_x, point_y
  logic [3:0]                     out_tuser;  // point_kind, status
  logic                           cfg_wr_en, cfg_addr;
  logic [psx_pkg::MM_W-1:0]       cfg_data;

  polyline_section_extractor u_top (.*);

  // predictor state
  logic [psx_pkg::MM_W-1:0]           chain_start_mm, chain_end_mm;
  logic signed [psx_pkg::COORD_W-1:0] line_prev_x, line_prev_y;
  logic [63:0]                        line_len;
  bit                                 line_open, cut_start_done, cut_end_done;
  int                                 line_points;

  point_t pending_points[$];
  int     err_count;
  int     sent_count;
  int     tx_idle_pct, rx_stall_pct;
  logic   hold_rx;
  row_t   rows[$];

  function automatic logic [63:0] mm_to_deg(logic [psx_pkg::MM_W-1:0] mm);
    return (64'(mm) << FRAC) / 64'(psx_pkg::MM_PER_DEG);
  endfunction

  function automatic logic [63:0] seg_len(logic [63:0] adx, logic [63:0] ady);
    logic [127:0] sq, c;
    logic [63:0]  res;
    sq  = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
    res = 0;
    for (int b = 42; b >= 0; b--) begin
      c = 128'(res | (64'd1 << b));
      if (c * c <= sq) res = c[63:0];
    end
    return res;
  endfunction

  function automatic logic [63:0] cut_frac(logic [63:0] chain, logic [63:0] prior,
                                           logic [63:0] seg);
    logic [63:0] n;
    if (seg == 0) return 0;
    n = (chain > prior) ? chain - prior : 0;
    if (n >= seg) return 64'd1 << psx_pkg::FACT_BITS;
    return 64'((128'(n) << psx_pkg::FACT_BITS) / 128'(seg));
  endfunction

  function automatic logic signed [psx_pkg::COORD_W-1:0] cut_at(
      logic signed [psx_pkg::COORD_W-1:0] p,
      logic signed [psx_pkg::COORD_W-1:0] c,
      logic [63:0] f);
    logic signed [63:0] d, r;
    logic [63:0]        ad, off;
    d   = 64'(c) - 64'(p);
    ad  = (d < 0) ? 64'(-d) : 64'(d);
    off = 64'((128'(ad) * 128'(f)) >> psx_pkg::FACT_BITS);
    r   = (d < 0) ? 64'(p) - $signed(off) : 64'(p) + $signed(off);
    return r[psx_pkg::COORD_W-1:0];
  endfunction

  function automatic void add_point(logic signed [psx_pkg::COORD_W-1:0] x,
                                    logic signed [psx_pkg::COORD_W-1:0] y,
                                    psx_pkg::kind_t k);
    pending_points.push_back('{x, y, k, psx_pkg::ST_OK, 1'b0});
    if (k != psx_pkg::KIND_STATUS && line_points < 2) line_points++;
  endfunction

  task automatic extract_section(logic signed [psx_pkg::COORD_W-1:0] cx,
                                 logic signed [psx_pkg::COORD_W-1:0] cy, logic fin);
    logic [63:0] s, e, seg, prior, total;
    logic signed [63:0] dx, dy;
    bit bad;
    int q0;
    q0  = pending_points.size();
    bad = chain_start_mm >= chain_end_mm;
    if (!line_open) begin
      line_prev_x = cx;
      line_prev_y = cy;
      line_len    = 0;
      line_open   = 1;
    end else if (!cut_end_done) begin
      s     = mm_to_deg(chain_start_mm);
      e     = mm_to_deg(chain_end_mm);
      dx    = 64'(cx) - 64'(line_prev_x);
      dy    = 64'(cy) - 64'(line_prev_y);
      seg   = seg_len(dx < 0 ? 64'(-dx) : 64'(dx), dy < 0 ? 64'(-dy) : 64'(dy));
      prior = line_len;
      total = (seg > LEN_SAT - prior) ? LEN_SAT : prior + seg;
      if (!bad) begin
        if (!cut_start_done && total >= s) begin
          add_point(cut_at(line_prev_x, cx, cut_frac(s, prior, seg)),
                    cut_at(line_prev_y, cy, cut_frac(s, prior, seg)),
                    psx_pkg::KIND_START);
          cut_start_done = 1;
        end
        if (cut_start_done && total <= e) add_point(cx, cy, psx_pkg::KIND_MID);
        if (total >= e) begin
          add_point(cut_at(line_prev_x, cx, cut_frac(e, prior, seg)),
                    cut_at(line_prev_y, cy, cut_frac(e, prior, seg)),
                    psx_pkg::KIND_END);
          cut_end_done = 1;
        end
      end
      line_prev_x = cx;
      line_prev_y = cy;
      line_len    = total;
    end
    if (fin) begin
      add_point('0, '0, psx_pkg::KIND_STATUS);
      pending_points[pending_points.size()-1].st =
        (bad || line_points < 2) ? psx_pkg::ST_BAD :
        (!cut_end_done ? psx_pkg::ST_UNREACHED : psx_pkg::ST_OK);
      line_prev_x = 0; line_prev_y = 0; line_len = 0;
      line_open = 0; cut_start_done = 0; cut_end_done = 0; line_points = 0;
    end
    if (pending_points.size() > q0) pending_points[pending_points.size()-1].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %s: got %0h, expected %0h", what, got, want);
    err_count++;
  endtask

  // send one vertex; returns at the accepting edge
  task automatic send_vertex(logic signed [psx_pkg::COORD_W-1:0] x,
                             logic signed [psx_pkg::COORD_W-1:0] y, logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {y, x};
    in_tlast  <= fin;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    extract_section(x, y, fin);
    sent_count++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [psx_pkg::MM_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (addr == psx_pkg::CFG_START) chain_start_mm = data;
    else chain_end_mm = data;
    @(posedge clk);
  endtask

  function automatic void add_row(op_t op, logic signed [psx_pkg::COORD_W-1:0] x,
                                  logic signed [psx_pkg::COORD_W-1:0] y, logic l_or_a,
                                  logic [psx_pkg::MM_W-1:0] data, bit typed,
                                  psx_pkg::status_t st);
    row_t r;
    r.op = op; r.x = x; r.y = y; r.last = l_or_a; r.addr = l_or_a; r.data = data;
    r.typed = typed;
    r.exp = '{'0, '0, psx_pkg::KIND_STATUS, st, 1'b1};
    rows.push_back(r);
  endfunction

  function automatic logic signed [psx_pkg::COORD_W-1:0] rand_coord(int shift);
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return $signed(r[psx_pkg::COORD_W-1:0]) >>> shift;
  endfunction

  task automatic random_line();
    int n, sh;
    bit noise;
    logic signed [psx_pkg::COORD_W-1:0] x, y, dx, dy;
    n     = $urandom_range(1, 8);
    noise = $urandom_range(99) < 15;
    x = rand_coord(noise ? 0 : 2);
    y = rand_coord(noise ? 0 : 2);
    for (int i = 0; i < n; i++) begin
      send_vertex(x, y, (i == n - 1) && ($urandom_range(99) < 95));
      if (noise) begin
        x = rand_coord(0);
        y = rand_coord(0);
      end else if ($urandom_range(99) >= 10) begin
        sh = $urandom_range(8, 25);
        dx = rand_coord(39 - sh);
        dy = rand_coord(39 - sh);
        x  = x + dx;
        y  = y + dy;
      end
    end
  endtask

  task automatic random_config();
    logic [psx_pkg::MM_W-1:0] s, e;
    s = $urandom_range(0, 8000000);
    if ($urandom_range(99) < 15) e = $urandom_range(0, s);
    else e = s + $urandom_range(1, 10000000);
    if ($urandom_range(99) < 5) s = '0;
    if ($urandom_range(99) < 5) e = '1;
    wait_idle();
    write_reg(psx_pkg::CFG_START, s);
    write_reg(psx_pkg::CFG_END, e);
  endtask

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL polyline_section_extractor");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_rx) out_tready <= 1'b0;
    else out_tready <= $urandom_range(99) >= rx_stall_pct;
  end

  // one long output hold-off while the sender keeps going
  initial begin
    hold_rx = 1'b0;
    wait (sent_count >= 120);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (1500) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("beat with nothing expected",
                        64'(out_tdata[psx_pkg::COORD_W-1:0]), 64'd0);
      end else begin
        want = pending_points.pop_front();
        if (out_tdata[psx_pkg::COORD_W-1:0] !== want.x)
          report_mismatch("point_x", 64'(out_tdata[psx_pkg::COORD_W-1:0]),
                          64'(want.x));
        if (out_tdata[2*psx_pkg::COORD_W-1:psx_pkg::COORD_W] !== want.y)
          report_mismatch("point_y",
                          64'(out_tdata[2*psx_pkg::COORD_W-1:psx_pkg::COORD_W]),
                          64'(want.y));
        if (out_tuser[1:0] !== want.kind)
          report_mismatch("kind", 64'(out_tuser[1:0]), 64'(want.kind));
        if (out_tuser[3:2] !== want.st)
          report_mismatch("status", 64'(out_tuser[3:2]), 64'(want.st));
        if (out_tlast !== want.last)
          report_mismatch("run_last", 64'(out_tlast), 64'(want.last));
      end
    end
  end

  initial begin
    logic signed [psx_pkg::COORD_W-1:0] cmax, cmin;
    int guard;
    cmax = {1'b0, {(psx_pkg::COORD_W-1){1'b1}}};
    cmin = {1'b1, {(psx_pkg::COORD_W-1){1'b0}}};
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0;
    cfg_wr_en = 1'b0; cfg_addr = 1'b0; cfg_data = '0;
    err_count = 0; sent_count = 0; tx_idle_pct = 0; rx_stall_pct = 0;
    chain_start_mm = 0; chain_end_mm = 0;
    line_prev_x = 0; line_prev_y = 0; line_len = 0;
    line_open = 0; cut_start_done = 0; cut_end_done = 0; line_points = 0;

    // registers at reset give a bad range
    add_row(OP_VTX, 0, 0, 1, 0, 1, psx_pkg::ST_BAD);
    add_row(OP_VTX, cmax, cmin, 0, 0, 0, psx_pkg::ST_OK);
    add_row(OP_VTX, cmin, cmax, 1, 0, 1, psx_pkg::ST_BAD);
    add_row(OP_CFG, 0, 0, psx_pkg::CFG_START, 0, 0, psx_pkg::ST_OK);
    add_row(OP_CFG, 0, 0, psx_pkg::CFG_END, 2000000, 0, psx_pkg::ST_OK);
    add_row(OP_VTX, 0, 0, 0, 0, 0, psx_pkg::ST_OK);
    add_row(OP_VTX, 0, 0, 0, 0, 0, psx_pkg::ST_OK);
    add_row(OP_VTX, 40'sd67108864, 0, 0, 0, 0, psx_pkg::ST_OK);
    add_row(OP_VTX, 5, 5, 0, 0, 0, psx_pkg::ST_OK);
    add_row(OP_VTX, 7, 7, 1, 0, 0, psx_pkg::ST_OK);
    add_row(OP_VTX, 0, 0, 0, 0, 0, psx_pkg::ST_OK);
    add_row(OP_CFG, 0, 0, psx_pkg::CFG_START, 1000000, 0, psx_pkg::ST_OK);
    add_row(OP_CFG, 0, 0, psx_pkg::CFG_END, 32'hFFFF_FFFF, 0, psx_pkg::ST_OK);
    add_row(OP_VTX, 40'sd16777216, 40'sd16777216, 0, 0, 0, psx_pkg::ST_OK);
    add_row(OP_VTX, 40'sd33554432, -40'sd1000, 1, 0, 0, psx_pkg::ST_OK);
    add_row(OP_CFG, 0, 0, psx_pkg::CFG_START, 0, 0, psx_pkg::ST_OK);
    add_row(OP_VTX, cmin, cmin, 0, 0, 0, psx_pkg::ST_OK);
    add_row(OP_VTX, cmax, cmax, 0, 0, 0, psx_pkg::ST_OK);
    add_row(OP_VTX, 0, 0, 1, 0, 0, psx_pkg::ST_OK);
    add_row(OP_CFG, 0, 0, psx_pkg::CFG_START, 4000000000, 0, psx_pkg::ST_OK);
    add_row(OP_VTX, 0, 0, 0, 0, 0, psx_pkg::ST_OK);
    add_row(OP_VTX, 40'sd1024, 0, 1, 0, 1, psx_pkg::ST_BAD);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].op == OP_CFG) begin
        wait_idle();
        write_reg(rows[i].addr, rows[i].data);
      end else begin
        send_vertex(rows[i].x, rows[i].y, rows[i].last);
        if (rows[i].typed) pending_points[pending_points.size()-1] = rows[i].exp;
      end
    end

    while (sent_count < N_ITEMS) begin
      case (sent_count * 4 / N_ITEMS)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      if ($urandom_range(5) == 0) random_config();
      random_line();
    end
    send_vertex(0, 0, 1'b1);
    in_tvalid <= 1'b0;

    guard = 0;
    while (pending_points.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (err_count == 0 && pending_points.size() == 0) begin
      $display("PASS polyline_section_extractor");
    end else begin
      $display("FAIL polyline_section_extractor");
    end
    $finish;
  end

endmodule

### polyline_section_extractor.f
rtl/psx_pkg.sv
rtl/psx_mm2deg.sv
rtl/polyline_section_extractor.sv
dv/tb.sv
